@@ src/timer_event_queue_defines.svh @@
// assertion macros used by the timer event queue checker
`ifndef TIMER_EVENT_QUEUE_DEFINES_SVH
`define TIMER_EVENT_QUEUE_DEFINES_SVH

// same-cycle implication
`define TEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer_event_queue same-cycle check failed");

// next-cycle implication
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer_event_queue next-cycle check failed");

`endif

@@ src/teq_pkg.sv @@
`default_nettype none

package teq_pkg;

   localparam int DEFAULT_EVENT_SLOTS = 16;
   localparam int MAX_FIRE            = 16;
   localparam int FIRE_W              = $clog2(MAX_FIRE);

   localparam int OP_W    = 2;
   localparam int ID_W    = 4;
   localparam int TIME_W  = 64;
   localparam int ORDER_W = 32;
   localparam int KIND_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ATTACH  = 2'd0,
      OP_DETACH  = 2'd1,
      OP_TICK    = 2'd2,
      OP_IGNORED = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK   = 2'd0,
      KIND_FIRED = 2'd1,
      KIND_NONE  = 2'd2
   } kind_type;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_NOT_ARMED  = 1'b1;

   typedef struct packed {
      logic accept;
      logic scan_start;
      logic load_ack;
      logic load_fire;
      logic load_none;
   } teq_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic is_last;
      logic out_free;
   } teq_stat_type;

endpackage

`default_nettype wire

@@ src/teq_if.sv @@
`default_nettype none

interface teq_req_if;
   import teq_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [ID_W-1:0]     event_id;
   logic [TIME_W-1:0]   expire_time;
   logic [TIME_W-1:0]   now_time;

   modport source (output valid, output op, output event_id, output expire_time,
                   output now_time, input ready);
   modport sink (input valid, input op, input event_id, input expire_time,
                 input now_time, output ready);
endinterface

interface teq_rsp_if;
   import teq_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [ID_W-1:0]     fired_id;
   logic                status;
   logic                last;

   modport source (output valid, output kind, output fired_id, output status,
                   output last, input ready);
   modport sink (input valid, input kind, input fired_id, input status,
                 input last, output ready);
endinterface

`default_nettype wire

@@ src/teq_ctrl.sv @@
`default_nettype none

module teq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [teq_pkg::OP_W-1:0]  req_op,
   output logic                      req_ready,
   output teq_pkg::teq_cmd_type      cmd,
   input  teq_pkg::teq_stat_type     stat
);
   import teq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ACK,
      S_FIRE,
      S_NONE
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (op_type'(req_op))
                  OP_ATTACH, OP_DETACH: state_in = S_ACK;
                  OP_TICK: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.found ? S_FIRE : S_NONE;
            end
         end
         S_ACK: begin
            if (stat.out_free) begin
               cmd.load_ack = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIRE: begin
            if (stat.out_free) begin
               cmd.load_fire = 1'b1;
               if (stat.is_last) begin
                  state_in = S_IDLE;
               end else begin
                  // next round of the search over the remaining due events
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_NONE: begin
            if (stat.out_free) begin
               cmd.load_none = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/teq_dpath.sv @@
`default_nettype none

module teq_dpath #(
   parameter int EVENT_SLOTS = teq_pkg::DEFAULT_EVENT_SLOTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  teq_pkg::teq_cmd_type          cmd,
   output teq_pkg::teq_stat_type         stat,
   input  logic [teq_pkg::OP_W-1:0]      req_op,
   input  logic [teq_pkg::ID_W-1:0]      req_id,
   input  logic [teq_pkg::TIME_W-1:0]    req_expire,
   input  logic [teq_pkg::TIME_W-1:0]    req_now,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [teq_pkg::KIND_W-1:0]    rsp_kind,
   output logic [teq_pkg::ID_W-1:0]      rsp_fired_id,
   output logic                          rsp_status,
   output logic                          rsp_last
);
   import teq_pkg::*;

   localparam int SLOT_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
   localparam int EXT_W  = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(EVENT_SLOTS - 1);

   // slot storage, read one slot per cycle during a scan
   logic [TIME_W-1:0]  expiry_mem [EVENT_SLOTS];
   logic [ORDER_W-1:0] order_mem  [EVENT_SLOTS];
   logic [TIME_W-1:0]  exp_rd_ff;
   logic [ORDER_W-1:0] ord_rd_ff;

   logic [EVENT_SLOTS-1:0] armed_ff, armed_in;
   logic [ORDER_W-1:0]     arrival_ff, arrival_in;
   logic [ID_W-1:0]        id_ff, id_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic                   ack_status_ff, ack_status_in;
   logic [FIRE_W-1:0]      fire_cnt_ff, fire_cnt_in;

   logic [SLOT_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                   issue_ff, issue_in;

   logic                   rd_valid_ff, rd_valid_in;
   logic                   rd_armed_ff, rd_armed_in;
   logic [SLOT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                   rd_last_ff, rd_last_in;

   logic                   st_valid_ff, st_valid_in;
   logic                   st_due_ff, st_due_in;
   logic [TIME_W-1:0]      st_exp_ff, st_exp_in;
   logic [ORDER_W-1:0]     st_age_ff, st_age_in;
   logic [SLOT_W-1:0]      st_idx_ff, st_idx_in;
   logic                   st_last_ff, st_last_in;

   logic                   best_found_ff, best_found_in;
   logic [TIME_W-1:0]      best_exp_ff, best_exp_in;
   logic [ORDER_W-1:0]     best_age_ff, best_age_in;
   logic [SLOT_W-1:0]      best_idx_ff, best_idx_in;
   logic                   more_ff, more_in;
   logic                   done_ff, done_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic                   rsp_status_ff, rsp_status_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [EXT_W-1:0]       id_ext;
   logic                   id_in_range;
   logic [SLOT_W-1:0]      id_slot;
   logic                   attach_we;
   logic                   detach_hit;
   logic                   better;
   logic                   is_last;
   logic                   out_free;

   assign id_ext      = EXT_W'(req_id);
   assign id_in_range = id_ext < EXT_W'(EVENT_SLOTS);
   assign id_slot     = id_ext[SLOT_W-1:0];
   assign attach_we   = cmd.accept && (req_op == OP_ATTACH) && id_in_range;
   assign detach_hit  = cmd.accept && (req_op == OP_DETACH) && id_in_range
                        && armed_ff[id_slot];

   // earlier expiry wins, then the older arrival; equal age keeps the lower slot
   assign better  = (st_exp_ff < best_exp_ff)
                    || ((st_exp_ff == best_exp_ff) && (st_age_ff > best_age_ff));
   assign is_last = !more_ff || (fire_cnt_ff == FIRE_W'(MAX_FIRE - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (attach_we) begin
         expiry_mem[id_slot] <= req_expire;
         order_mem[id_slot]  <= arrival_ff;
      end
      exp_rd_ff <= expiry_mem[scan_idx_ff];
      ord_rd_ff <= order_mem[scan_idx_ff];
   end

   always_comb begin
      armed_in      = armed_ff;
      arrival_in    = arrival_ff;
      id_in         = id_ff;
      now_in        = now_ff;
      ack_status_in = ack_status_ff;
      fire_cnt_in   = fire_cnt_ff;
      scan_idx_in   = scan_idx_ff;
      issue_in      = issue_ff;
      best_found_in = best_found_ff;
      best_exp_in   = best_exp_ff;
      best_age_in   = best_age_ff;
      best_idx_in   = best_idx_ff;
      more_in       = more_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.accept) begin
         id_in         = req_id;
         now_in        = req_now;
         fire_cnt_in   = '0;
         ack_status_in = ((req_op == OP_DETACH) && !detach_hit) ? STATUS_NOT_ARMED
                                                                 : STATUS_OK;
         if (attach_we) begin
            armed_in[id_slot] = 1'b1;
            arrival_in        = arrival_ff + 1'b1;
         end
         if (detach_hit) begin
            armed_in[id_slot] = 1'b0;
         end
      end

      // slot scan address
      if (cmd.scan_start) begin
         scan_idx_in   = '0;
         issue_in      = 1'b1;
         best_found_in = 1'b0;
         more_in       = 1'b0;
      end else if (issue_ff) begin
         if (scan_idx_ff == LAST_SLOT) begin
            issue_in = 1'b0;
         end else begin
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end

      // keep the best due slot seen so far
      if (st_valid_ff && st_due_ff) begin
         if (!best_found_ff || better) begin
            best_exp_in = st_exp_ff;
            best_age_in = st_age_ff;
            best_idx_in = st_idx_ff;
         end
         if (best_found_ff) begin
            more_in = 1'b1;
         end
         best_found_in = 1'b1;
      end

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_ACK;
         rsp_id_in     = id_ff;
         rsp_status_in = ack_status_ff;
         rsp_last_in   = 1'b1;
      end
      if (cmd.load_fire) begin
         armed_in[best_idx_ff] = 1'b0;
         fire_cnt_in   = fire_cnt_ff + 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_FIRED;
         rsp_id_in     = ID_W'(best_idx_ff);
         rsp_status_in = STATUS_OK;
         rsp_last_in   = is_last;
      end
      if (cmd.load_none) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = KIND_NONE;
         rsp_id_in     = '0;
         rsp_status_in = STATUS_OK;
         rsp_last_in   = 1'b1;
      end
   end

   assign rd_valid_in = issue_ff;
   assign rd_armed_in = armed_ff[scan_idx_ff];
   assign rd_idx_in   = scan_idx_ff;
   assign rd_last_in  = (scan_idx_ff == LAST_SLOT);

   assign st_valid_in = rd_valid_ff;
   assign st_due_in   = rd_armed_ff && (exp_rd_ff <= now_ff);
   assign st_exp_in   = exp_rd_ff;
   assign st_age_in   = arrival_ff - ord_rd_ff;
   assign st_idx_in   = rd_idx_ff;
   assign st_last_in  = rd_last_ff;

   assign done_in = st_valid_ff && st_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= '0;
         arrival_ff    <= '0;
         issue_ff      <= 1'b0;
         rd_valid_ff   <= 1'b0;
         st_valid_ff   <= 1'b0;
         best_found_ff <= 1'b0;
         more_ff       <= 1'b0;
         done_ff       <= 1'b0;
         fire_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         armed_ff      <= armed_in;
         arrival_ff    <= arrival_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         st_valid_ff   <= st_valid_in;
         best_found_ff <= best_found_in;
         more_ff       <= more_in;
         done_ff       <= done_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      now_ff        <= now_in;
      ack_status_ff <= ack_status_in;
      scan_idx_ff   <= scan_idx_in;
      rd_armed_ff   <= rd_armed_in;
      rd_idx_ff     <= rd_idx_in;
      rd_last_ff    <= rd_last_in;
      st_due_ff     <= st_due_in;
      st_exp_ff     <= st_exp_in;
      st_age_ff     <= st_age_in;
      st_idx_ff     <= st_idx_in;
      st_last_ff    <= st_last_in;
      best_exp_ff   <= best_exp_in;
      best_age_ff   <= best_age_in;
      best_idx_ff   <= best_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.scan_done = done_ff;
   assign stat.found     = best_found_ff;
   assign stat.is_last   = is_last;
   assign stat.out_free  = out_free;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_fired_id = rsp_id_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire

@@ src/timer_event_queue.sv @@
// Timer event queue: one slot per event id, each holding an armed bit, a 64-bit expiry
// and an arrival order. Attach arms a slot (re-arming it with a fresh arrival order),
// detach disarms it, and tick fires every armed slot due at the given time, earliest
// expiry first and older attach first on ties, up to 16 per tick with the rest left
// armed. Attach and detach wait in an acknowledge state while the result register is
// still full; an ignored opcode is taken without a result. A tick runs one search
// round per fired event, or one round when nothing is due; each round is a slot scan
// that reads the expiry and order memory through its single read port one slot per
// cycle. The result register lets a new transaction be taken while the previous
// result waits.
`default_nettype none

module timer_event_queue #(
   parameter int EVENT_SLOTS = teq_pkg::DEFAULT_EVENT_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   teq_req_if.sink    req_ch,
   teq_rsp_if.source  rsp_ch
);
   import teq_pkg::*;

   teq_cmd_type  cmd;
   teq_stat_type stat;
   logic         ready;

   assign req_ch.ready = ready;

   teq_ctrl u_teq_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   teq_dpath #(
      .EVENT_SLOTS (EVENT_SLOTS)
   ) u_teq_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_ch.op),
      .req_id       (req_ch.event_id),
      .req_expire   (req_ch.expire_time),
      .req_now      (req_ch.now_time),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_kind     (rsp_ch.kind),
      .rsp_fired_id (rsp_ch.fired_id),
      .rsp_status   (rsp_ch.status),
      .rsp_last     (rsp_ch.last)
   );

endmodule

`default_nettype wire

@@ src/teq_checker.sv @@
`default_nettype none
`include "timer_event_queue_defines.svh"

module teq_prop_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [teq_pkg::OP_W-1:0]    req_op,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [teq_pkg::KIND_W-1:0]  rsp_kind,
   input logic [teq_pkg::ID_W-1:0]    rsp_fired_id,
   input logic                        rsp_status,
   input logic                        rsp_last
);
   import teq_pkg::*;

   logic req_real;
   logic rsp_none;
   logic none_clean;
   logic rsp_not_armed;

   assign req_real      = req_valid && req_ready && (req_op != OP_IGNORED);
   assign rsp_none      = rsp_valid && (rsp_kind == KIND_NONE);
   assign none_clean    = (rsp_fired_id == '0) && (rsp_status == STATUS_OK);
   assign rsp_not_armed = rsp_valid && (rsp_status == STATUS_NOT_ARMED);

   // a pending result is never withdrawn
   `TEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // a real transaction leaves the block busy in the following cycle
   `TEQ_ASSERT_NEXT(a_busy_after_req, clock, reset, req_real, !req_ready)

   // acknowledges and empty ticks are single results
   `TEQ_ASSERT_SAME(a_single_last, clock, reset, rsp_valid && rsp_kind != KIND_FIRED, rsp_last)

   `TEQ_ASSERT_SAME(a_none_clean, clock, reset, rsp_none, none_clean)

   `TEQ_ASSERT_SAME(a_status_ack, clock, reset, rsp_not_armed, rsp_kind == KIND_ACK)

endmodule

bind timer_event_queue teq_prop_checker u_teq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_op       (req_ch.op),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_kind     (rsp_ch.kind),
   .rsp_fired_id (rsp_ch.fired_id),
   .rsp_status   (rsp_ch.status),
   .rsp_last     (rsp_ch.last)
);

`default_nettype wire
